// ===== src/tmf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants, row layout and controller/datapath interface types for
// the temporal median filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  // sizing of the filter
  localparam int unsigned NUM_BEAMS     = 512;
  localparam int unsigned HISTORY_DEPTH = 32;

  // field widths
  localparam int unsigned BEAM_W  = 9;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned MED_W   = 17;
  localparam int unsigned CNT_W   = 6;

  // memory addressing and lane indexing
  localparam int unsigned ADDR_W = (NUM_BEAMS > 1) ? $clog2(NUM_BEAMS) : 1;
  localparam int unsigned IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // one memory row: history lanes at the bottom, sample count on top
  localparam int unsigned HIST_W = HISTORY_DEPTH * RANGE_W;
  localparam int unsigned ROW_W  = HIST_W + CNT_W;

  // controller to datapath commands
  typedef struct packed {
    logic clr_write;
    logic capture;
    logic rd_en;
    logic insert;
    logic out_load;
  } tmf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } tmf_sts_t;

endpackage

// ===== src/temporal_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// temporal_median_filter_unit
// Per-beam sorted sample history with median output in half millimetres.
//
//   channel  handshake            word fields
//   -------  -------------------  ----------------------------------------
//   in       in_valid / in_ready  beam, range_mm
//   out      out_valid/ out_ready beam_out, median_half_mm, history_count,
//                                 overflow
//
// Each word passes accept, row read, insert with write-back, median and output
// load in turn; a new word is accepted only once the last one is loaded.
// After reset a clearing pass over all NUM_BEAMS rows (512) zeroes the
// per-beam counts; in_ready stays low throughout.
// A finished word waits in the output register; the next input word is
// accepted meanwhile, and only its median stage stalls on a full output.
// ----------------------------------------------------------------------------
module temporal_median_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmf_pkg::BEAM_W-1:0]    beam,
  input  logic [tmf_pkg::RANGE_W-1:0]   range_mm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmf_pkg::BEAM_W-1:0]    beam_out,
  output logic [tmf_pkg::MED_W-1:0]     median_half_mm,
  output logic [tmf_pkg::CNT_W-1:0]     history_count,
  output logic                          overflow
);
  import tmf_pkg::*;

  tmf_cmd_t cmd;
  tmf_sts_t sts;

  // sequencer
  tmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // history memory, insert and median
  tmf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .beam           (beam),
    .range_mm       (range_mm),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .beam_out       (beam_out),
    .median_half_mm (median_half_mm),
    .history_count  (history_count),
    .overflow       (overflow)
  );

endmodule

// ===== src/tmf_ram.sv =====
// ----------------------------------------------------------------------------
// tmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmf_ctrl
// Sequencer for the median filter: clearing pass after reset, then
// capture, row read, insert and write-back, median and output load.
// ----------------------------------------------------------------------------
module tmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmf_pkg::tmf_sts_t sts,
  output tmf_pkg::tmf_cmd_t cmd
);
  import tmf_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_INSERT = 5'b01000,
    S_MEDIAN = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_MEDIAN;
      end
      S_MEDIAN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/tmf_datapath.sv =====
// ----------------------------------------------------------------------------
// tmf_datapath
// History row memory, parallel sorted insert over all lanes, median select
// and the output word register.
// ----------------------------------------------------------------------------
module tmf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tmf_pkg::tmf_cmd_t             cmd,
  output tmf_pkg::tmf_sts_t             sts,
  input  logic [tmf_pkg::BEAM_W-1:0]    beam,
  input  logic [tmf_pkg::RANGE_W-1:0]   range_mm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmf_pkg::BEAM_W-1:0]    beam_out,
  output logic [tmf_pkg::MED_W-1:0]     median_half_mm,
  output logic [tmf_pkg::CNT_W-1:0]     history_count,
  output logic                          overflow
);
  import tmf_pkg::*;

  // captured input word
  logic [BEAM_W-1:0]  beam_q;
  logic [RANGE_W-1:0] range_q;
  logic               oor_q;

  // clearing pass address
  logic [ADDR_W-1:0]  clr_addr;

  // memory ports
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ROW_W-1:0]   ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ROW_W-1:0]   ram_rd_data;

  // insert stage
  logic [RANGE_W-1:0] row_in  [HISTORY_DEPTH];
  logic [RANGE_W-1:0] row_ins [HISTORY_DEPTH];
  logic [RANGE_W-1:0] row_new [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] lt;
  logic [HIST_W-1:0]  row_new_flat;
  logic [CNT_W-1:0]   cnt_raw;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_new;
  logic               full;

  // median stage
  logic [RANGE_W-1:0] row_q   [HISTORY_DEPTH];
  logic [RANGE_W-1:0] lo_cand [HISTORY_DEPTH];
  logic [CNT_W-1:0]   cnt_q;
  logic               ovf_q;
  logic [CNT_W-1:0]   half_cnt;
  logic [IDX_W-1:0]   mid_idx;
  logic [RANGE_W-1:0] mid_lo;
  logic [RANGE_W-1:0] mid_hi;
  logic [MED_W-1:0]   median;

  // capture of the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      beam_q  <= beam;
      range_q <= range_mm;
      oor_q   <= (32'(beam) >= 32'(NUM_BEAMS));
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == ADDR_W'(NUM_BEAMS - 1));
  assign sts.out_free = !out_valid || out_ready;

  // row unpack and count clamp
  always_comb begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      row_in[k] = ram_rd_data[k*RANGE_W +: RANGE_W];
    end
    cnt_raw = ram_rd_data[ROW_W-1 -: CNT_W];
    cnt_cur = (cnt_raw > CNT_W'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH) : cnt_raw;
    full    = (cnt_cur == CNT_W'(HISTORY_DEPTH));
  end

  // held entries below the new sample form a prefix of the row
  always_comb begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      lt[k] = (CNT_W'(k) < cnt_cur) && (row_in[k] < range_q);
    end
  end

  // sorted insert: keep, place sample, or shift up by one lane
  always_comb begin
    row_ins[0] = lt[0] ? row_in[0] : range_q;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      if (lt[k]) begin
        row_ins[k] = row_in[k];
      end else if (lt[k-1]) begin
        row_ins[k] = range_q;
      end else begin
        row_ins[k] = row_in[k-1];
      end
    end
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      row_new[k] = full ? row_in[k] : row_ins[k];
      row_new_flat[k*RANGE_W +: RANGE_W] = row_new[k];
    end
    cnt_new = full ? cnt_cur : cnt_cur + 1'b1;
  end

  // write: zero rows when clearing, else write-back if in range, not full
  always_comb begin
    ram_wr_en   = cmd.clr_write || (cmd.insert && !oor_q && !full);
    ram_wr_addr = cmd.clr_write ? clr_addr : ADDR_W'(beam_q);
    ram_wr_data = cmd.clr_write ? '0 : {cnt_new, row_new_flat};
  end

  assign ram_rd_addr = ADDR_W'(beam_q);

  tmf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BEAMS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // updated row held for the median stage
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      row_q <= row_new;
      cnt_q <= oor_q ? '0 : cnt_new;
      ovf_q <= !oor_q && full;
    end
  end

  // median select: lower middle comes from the lane below for even counts
  always_comb begin
    half_cnt   = cnt_q >> 1;
    mid_idx    = half_cnt[IDX_W-1:0];
    lo_cand[0] = row_q[0];
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      lo_cand[k] = cnt_q[0] ? row_q[k] : row_q[k-1];
    end
    mid_lo = lo_cand[mid_idx];
    mid_hi = row_q[mid_idx];
    if (cnt_q == '0) begin
      median = '0;
    end else begin
      median = MED_W'(mid_lo) + MED_W'(mid_hi);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      beam_out       <= beam_q;
      median_half_mm <= median;
      history_count  <= cnt_q;
      overflow       <= ovf_q;
    end
  end

endmodule
